// File: design/lseg_pkg.sv
`default_nettype none

package lseg_pkg;

    // fixed widths of the internal counters
    localparam int CNT_W   = 6;
    localparam int NUM_W   = 5;
    localparam int FRAME_W = 11;
    localparam int DIV3_W  = 10;

    // effect codes
    localparam logic [2:0] EFF_WIPE     = 3'd0;
    localparam logic [2:0] EFF_RAINBOW  = 3'd1;
    localparam logic [2:0] EFF_CYCLE    = 3'd2;
    localparam logic [2:0] EFF_CHASE    = 3'd3;
    localparam logic [2:0] EFF_CHASE_RB = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_EFFECT = 3'd0;
    localparam logic [2:0] REG_RED    = 3'd1;
    localparam logic [2:0] REG_GREEN  = 3'd2;
    localparam logic [2:0] REG_BLUE   = 3'd3;
    localparam logic [2:0] REG_COUNT  = 3'd4;

    // effect lengths in frames
    localparam logic [FRAME_W:0] FRAMES_RAINBOW  = 12'd256;
    localparam logic [FRAME_W:0] FRAMES_CYCLE    = 12'd1280;
    localparam logic [FRAME_W:0] FRAMES_CHASE    = 12'd30;
    localparam logic [FRAME_W:0] FRAMES_CHASE_RB = 12'd768;
    localparam logic [FRAME_W:0] FRAMES_OTHER    = 12'd1;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic rnd_init;
        logic wipe_wr;
        logic rnd_step;
        logic advance;
        logic emit_init;
        logic rd;
        logic load;
        logic clr_init;
        logic clr_step;
    } lseg_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic finished;
        logic is_wipe;
        logic is_loop;
        logic is_chase;
        logic more;
        logic out_free;
    } lseg_stat_t;

    // quotient and remainder of 256 by the pixel count
    typedef struct packed {
        logic [8:0]       base;
        logic [NUM_W-1:0] rem;
    } cyc_step_t;

    function automatic cyc_step_t cyc_step(input logic [NUM_W-1:0] n);
        cyc_step_t r;
        case (n)
            5'd1:    r = {9'd256, 5'd0};
            5'd2:    r = {9'd128, 5'd0};
            5'd3:    r = {9'd85,  5'd1};
            5'd4:    r = {9'd64,  5'd0};
            5'd5:    r = {9'd51,  5'd1};
            5'd6:    r = {9'd42,  5'd4};
            5'd7:    r = {9'd36,  5'd4};
            5'd8:    r = {9'd32,  5'd0};
            5'd9:    r = {9'd28,  5'd4};
            5'd10:   r = {9'd25,  5'd6};
            5'd11:   r = {9'd23,  5'd3};
            5'd12:   r = {9'd21,  5'd4};
            5'd13:   r = {9'd19,  5'd9};
            5'd14:   r = {9'd18,  5'd4};
            5'd15:   r = {9'd17,  5'd1};
            5'd16:   r = {9'd16,  5'd0};
            5'd17:   r = {9'd15,  5'd1};
            5'd18:   r = {9'd14,  5'd4};
            5'd19:   r = {9'd13,  5'd9};
            5'd20:   r = {9'd12,  5'd16};
            5'd21:   r = {9'd12,  5'd4};
            5'd22:   r = {9'd11,  5'd14};
            5'd23:   r = {9'd11,  5'd3};
            5'd24:   r = {9'd10,  5'd16};
            5'd25:   r = {9'd10,  5'd6};
            5'd26:   r = {9'd9,   5'd22};
            5'd27:   r = {9'd9,   5'd13};
            5'd28:   r = {9'd9,   5'd4};
            5'd29:   r = {9'd8,   5'd24};
            5'd30:   r = {9'd8,   5'd16};
            5'd31:   r = {9'd8,   5'd8};
            default: r = {9'd0,   5'd0};
        endcase
        return r;
    endfunction

    function automatic logic [7:0] times3(input logic [7:0] x);
        return 8'({2'b00, x} + {1'b0, x, 1'b0});
    endfunction

    // three-segment colour wheel, result packed red, green, blue
    function automatic logic [23:0] wheel(input logic [7:0] pos);
        logic [7:0] p;
        logic [7:0] t;
        logic [23:0] c;
        p = 8'd255 - pos;
        if (p < 8'd85) begin
            t = times3(p);
            c = {8'd255 - t, 8'd0, t};
        end else if (p < 8'd170) begin
            t = times3(p - 8'd85);
            c = {8'd0, t, 8'd255 - t};
        end else begin
            t = times3(p - 8'd170);
            c = {t, 8'd255 - t, 8'd0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/lseg_ctrl.sv
`default_nettype none

module lseg_ctrl
    import lseg_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire lseg_stat_t stat,
    output lseg_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CHECK   = 3'd1;
    localparam logic [2:0] ST_RENDER  = 3'd2;
    localparam logic [2:0] ST_ADVANCE = 3'd3;
    localparam logic [2:0] ST_EMIT_RD = 3'd4;
    localparam logic [2:0] ST_EMIT_LD = 3'd5;
    localparam logic [2:0] ST_CLEAR   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       chase_reg;
    logic       chase_next;

    // state and chase flag registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            chase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            chase_reg <= chase_next;
        end
    end

    // sequencing of one frame tick: render, advance, emit, clear chase pixels
    always_comb begin
        state_next = state_reg;
        chase_next = chase_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.finished) begin
                    chase_next    = 1'b0;
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT_RD;
                end else begin
                    chase_next   = stat.is_chase;
                    cmd.rnd_init = 1'b1;
                    if (stat.is_wipe) begin
                        cmd.wipe_wr = 1'b1;
                        state_next  = ST_ADVANCE;
                    end else if (stat.is_loop) begin
                        state_next = ST_RENDER;
                    end else begin
                        state_next = ST_ADVANCE;
                    end
                end
            end
            ST_RENDER: begin
                if (stat.more) begin
                    cmd.rnd_step = 1'b1;
                end else begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE: begin
                cmd.advance   = 1'b1;
                cmd.emit_init = 1'b1;
                state_next    = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (stat.out_free) begin
                    cmd.load = 1'b1;
                    if (stat.more) begin
                        cmd.rd = 1'b1;
                    end else if (chase_reg) begin
                        cmd.clr_init = 1'b1;
                        state_next   = ST_CLEAR;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CLEAR: begin
                if (stat.more) begin
                    cmd.clr_step = 1'b1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

// File: design/lseg_dpath.sv
`default_nettype none

module lseg_dpath
    import lseg_pkg::*;
#(
    parameter int PIXELS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic [7:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    output logic             m_axis_tuser,
    input  wire lseg_cmd_t   cmd,
    output lseg_stat_t       stat
);

    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    logic [2:0]         eff_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;
    logic [NUM_W-1:0]   pc_reg;
    logic [NUM_W-1:0]   n;
    logic [23:0]        fixed;

    logic [FRAME_W-1:0] frame_reg;
    logic [1:0]         fmod3_reg;
    logic [DIV3_W-1:0]  fdiv3_reg;
    logic               fin_reg;
    logic [FRAME_W:0]   frames;
    logic [FRAME_W:0]   fr_inc;

    logic [CNT_W-1:0]   cnt_reg;
    logic [1:0]         cq_reg;
    logic [8:0]         qi_reg;
    logic [NUM_W-1:0]   rr_reg;
    cyc_step_t          cyc;
    logic [NUM_W:0]     rr_sum;
    logic               rr_wrap;
    logic [CNT_W-1:0]   step;

    logic [CNT_W-1:0]   ci;
    logic [DIV3_W-1:0]  rb_sum;
    logic [DIV3_W-1:0]  rb_mod;
    logic [7:0]         wheel_pos;
    logic [23:0]        rnd_color;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [23:0]        wr_data;
    logic [AW-1:0]      rd_addr;
    logic [23:0]        mem [PIXELS];
    logic [PIXELS-1:0]  valid_reg;
    logic [23:0]        rd_data_reg;
    logic [CNT_W-1:0]   rd_idx_reg;

    logic               m_valid_reg;
    logic [3:0]         px_idx_reg;
    logic [23:0]        px_reg;
    logic               last_reg;
    logic               done_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_reg   <= EFF_WIPE;
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
            pc_reg    <= 5'd10;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_EFFECT: eff_reg   <= cfg_wdata[2:0];
                REG_RED:    red_reg   <= cfg_wdata;
                REG_GREEN:  green_reg <= cfg_wdata;
                REG_BLUE:   blue_reg  <= cfg_wdata;
                REG_COUNT:  pc_reg    <= cfg_wdata[NUM_W-1:0];
                default: ;
            endcase
        end
    end

    // pixels in use, zero taken as one, saturated to the store size
    always_comb begin
        if (pc_reg == '0) begin
            n = 5'd1;
        end else if (32'(pc_reg) > PIXELS) begin
            n = 5'(PIXELS);
        end else begin
            n = pc_reg;
        end
    end

    assign fixed = {red_reg, green_reg, blue_reg};

    // effect length
    always_comb begin
        case (eff_reg)
            EFF_WIPE:     frames = {7'd0, n};
            EFF_RAINBOW:  frames = FRAMES_RAINBOW;
            EFF_CYCLE:    frames = FRAMES_CYCLE;
            EFF_CHASE:    frames = FRAMES_CHASE;
            EFF_CHASE_RB: frames = FRAMES_CHASE_RB;
            default:      frames = FRAMES_OTHER;
        endcase
    end

    assign fr_inc = {1'b0, frame_reg} + 12'd1;

    // frame number, kept with its quotient and remainder by three
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= '0;
            fmod3_reg <= '0;
            fdiv3_reg <= '0;
            fin_reg   <= 1'b1;
        end else if (cmd.accept && s_axis_tdata[0]) begin
            frame_reg <= '0;
            fmod3_reg <= '0;
            fdiv3_reg <= '0;
            fin_reg   <= 1'b0;
        end else if (cmd.advance) begin
            if (fr_inc >= frames) begin
                fin_reg <= 1'b1;
            end else begin
                frame_reg <= fr_inc[FRAME_W-1:0];
                if (fmod3_reg == 2'd2) begin
                    fmod3_reg <= 2'd0;
                    fdiv3_reg <= fdiv3_reg + 10'd1;
                end else begin
                    fmod3_reg <= fmod3_reg + 2'd1;
                end
            end
        end
    end

    // rainbow cycle offset i*256/n built up one pixel at a time
    assign cyc     = cyc_step(n);
    assign rr_sum  = {1'b0, rr_reg} + {1'b0, cyc.rem};
    assign rr_wrap = (rr_sum >= {1'b0, n});
    assign step    = stat.is_chase ? 6'd3 : 6'd1;

    // pixel counter and render accumulators
    always_ff @(posedge aclk) begin
        if (cmd.rnd_init) begin
            cnt_reg <= stat.is_chase ? {4'd0, fmod3_reg} : '0;
            cq_reg  <= fmod3_reg;
            qi_reg  <= '0;
            rr_reg  <= '0;
        end else if (cmd.rnd_step) begin
            cnt_reg <= cnt_reg + step;
            if (rr_wrap) begin
                rr_reg <= 5'(rr_sum - {1'b0, n});
                qi_reg <= qi_reg + cyc.base + 9'd1;
            end else begin
                rr_reg <= rr_sum[NUM_W-1:0];
                qi_reg <= qi_reg + cyc.base;
            end
        end else if (cmd.emit_init) begin
            cnt_reg <= '0;
        end else if (cmd.rd) begin
            cnt_reg <= cnt_reg + 6'd1;
        end else if (cmd.clr_init) begin
            cnt_reg <= {4'd0, cq_reg};
        end else if (cmd.clr_step) begin
            cnt_reg <= cnt_reg + 6'd3;
        end
    end

    // chase rainbow wheel position (i + f/3) mod 255
    assign ci     = cnt_reg - {4'd0, cq_reg};
    assign rb_sum = {4'd0, ci} + fdiv3_reg;
    always_comb begin
        if (rb_sum >= 10'd510) begin
            rb_mod = rb_sum - 10'd510;
        end else if (rb_sum >= 10'd255) begin
            rb_mod = rb_sum - 10'd255;
        end else begin
            rb_mod = rb_sum;
        end
    end

    // colour of the pixel being rendered
    always_comb begin
        case (eff_reg)
            EFF_RAINBOW: wheel_pos = {2'b00, cnt_reg} + frame_reg[7:0];
            EFF_CYCLE:   wheel_pos = qi_reg[7:0] + frame_reg[7:0];
            default:     wheel_pos = rb_mod[7:0];
        endcase
        rnd_color = (eff_reg == EFF_CHASE) ? fixed : wheel(wheel_pos);
    end

    // store write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[AW-1:0];
        wr_data = rnd_color;
        if (cmd.wipe_wr) begin
            wr_en   = (frame_reg < {6'd0, n});
            wr_addr = frame_reg[AW-1:0];
            wr_data = fixed;
        end else if (cmd.rnd_step) begin
            wr_en = 1'b1;
        end else if (cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_data = '0;
        end
    end

    assign rd_addr = cnt_reg[AW-1:0];

    // pixel store with registered read, unwritten entries read as off
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
            rd_idx_reg  <= cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_idx_reg <= rd_idx_reg[3:0];
            px_reg     <= rd_data_reg;
            last_reg   <= (rd_idx_reg == ({1'b0, n} - 6'd1));
            done_reg   <= fin_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, px_reg[7:0], px_reg[15:8], px_reg[23:16], px_idx_reg};
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = done_reg;

    // status to the controller
    assign stat.finished = fin_reg;
    assign stat.is_wipe  = (eff_reg == EFF_WIPE);
    assign stat.is_loop  = (eff_reg == EFF_RAINBOW) || (eff_reg == EFF_CYCLE)
                        || (eff_reg == EFF_CHASE) || (eff_reg == EFF_CHASE_RB);
    assign stat.is_chase = (eff_reg == EFF_CHASE) || (eff_reg == EFF_CHASE_RB);
    assign stat.more     = (cnt_reg < {1'b0, n});
    assign stat.out_free = !m_valid_reg || m_axis_tready;

endmodule

`default_nettype wire

// File: design/led_strip_effect_generator.sv
// LED strip effect generator. Each beat on the input channel is one frame tick:
// bit 0 of s_axis_tdata set restarts the selected effect at frame zero, clear
// advances it by one frame. The tick renders the frame into a pixel store of
// PIXELS entries (one write per cycle: n writes for rainbow and rainbow cycle,
// about n/3 for the chases, one for wipe, none for undefined effects), then
// streams the pixels in use, index ascending, one output beat per cycle while
// the sink is ready, with tlast on the final pixel and tuser set once the effect
// has reached its last frame. The chases then clear their lit pixels. Render,
// emit and clear run one after another at one pixel per cycle, the emit stalling
// while the sink holds tready low. The user must write registers through the cfg
// port only while no tick is in flight; the block itself does not enforce it.
`default_nettype none

module led_strip_effect_generator
    import lseg_pkg::*;
#(
    parameter int PIXELS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    // frame tick input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [0] restart
    // pixel output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [3:0] pixel_index, [11:4] red,
                                             // [19:12] green, [27:20] blue
    output logic             m_axis_tlast,   // last_pixel
    output logic             m_axis_tuser    // effect_done
);

    lseg_cmd_t  cmd;
    lseg_stat_t stat;

    lseg_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    lseg_dpath #(
        .PIXELS (PIXELS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

`default_nettype wire

// File: bench/lseg_pixel_checker.sv
module lseg_pixel_checker
    import lseg_pkg::*;
#(
    parameter int PIXELS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        m_tlast,
    input  wire logic        m_tuser,
    output int               mismatches,
    output int               beats_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // one pixel beat as the strip should see it
    typedef struct packed {
        logic [3:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
        logic       done;
    } pixel_beat_t;

    // shadow of the block's registers and frame state
    logic [23:0]  px_store [PIXELS];
    logic [10:0]  frame_no;
    logic         halted;
    logic [2:0]   effect;
    logic [7:0]   col_r, col_g, col_b;
    logic [4:0]   pix_count;

    pixel_beat_t  pixel_due [$];
    pixel_beat_t  seen, want;
    int           tally;
    int           n, f, q, span;
    logic [23:0]  fixed;
    logic         lit_chase;

    // three-segment wheel: red to green to blue and back
    function automatic logic [23:0] colour_wheel(input int pos);
        int p;
        p = 255 - (pos % 256);
        if (p < 85)
            return {8'(255 - 3 * p), 8'd0, 8'(3 * p)};
        if (p < 170)
            return {8'd0, 8'(3 * (p - 85)), 8'(255 - 3 * (p - 85))};
        return {8'(3 * (p - 170)), 8'(255 - 3 * (p - 170)), 8'd0};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("%0t: pixel mismatch on %s: got %0d, wanted %0d", $realtime, what, got,
                 exp_val);
        tally++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PIXELS; k++)
                px_store[k] = '0;
            frame_no  = '0;
            halted    = 1'b1;
            effect    = EFF_WIPE;
            col_r     = '0;
            col_g     = '0;
            col_b     = '0;
            pix_count = 5'd10;
            pixel_due.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_addr)
                    REG_EFFECT: effect    = cfg_wdata[2:0];
                    REG_RED:    col_r     = cfg_wdata;
                    REG_GREEN:  col_g     = cfg_wdata;
                    REG_BLUE:   col_b     = cfg_wdata;
                    REG_COUNT:  pix_count = cfg_wdata[4:0];
                    default: ;
                endcase
            end

            // frame tick: render into the shadow store and queue the pixels
            if (s_tvalid && s_tready) begin
                n = (pix_count == 0) ? 1 : (pix_count > PIXELS) ? PIXELS : int'(pix_count);
                fixed = {col_r, col_g, col_b};
                lit_chase = 1'b0;
                q = 0;
                if (s_tdata[0]) begin
                    frame_no = '0;
                    halted   = 1'b0;
                end
                f = int'(frame_no);
                if (!halted) begin
                    case (effect)
                        EFF_WIPE: begin
                            if (f < n)
                                px_store[f] = fixed;
                            span = n;
                        end
                        EFF_RAINBOW: begin
                            for (int i = 0; i < n; i++)
                                px_store[i] = colour_wheel(i + f);
                            span = int'(FRAMES_RAINBOW);
                        end
                        EFF_CYCLE: begin
                            for (int i = 0; i < n; i++)
                                px_store[i] = colour_wheel(i * 256 / n + f);
                            span = int'(FRAMES_CYCLE);
                        end
                        EFF_CHASE, EFF_CHASE_RB: begin
                            lit_chase = 1'b1;
                            q = f % 3;
                            for (int i = 0; i + q < n; i += 3)
                                px_store[i + q] = (effect == EFF_CHASE) ?
                                    fixed : colour_wheel((i + f / 3) % 255);
                            span = (effect == EFF_CHASE) ? int'(FRAMES_CHASE)
                                                         : int'(FRAMES_CHASE_RB);
                        end
                        default: span = int'(FRAMES_OTHER);
                    endcase
                    if (f + 1 >= span)
                        halted = 1'b1;
                    else
                        frame_no = 11'(f + 1);
                end
                for (int i = 0; i < n; i++) begin
                    want.idx   = 4'(i);
                    want.red   = px_store[i][23:16];
                    want.green = px_store[i][15:8];
                    want.blue  = px_store[i][7:0];
                    want.last  = (i == n - 1);
                    want.done  = halted;
                    pixel_due.push_back(want);
                end
                // chase pixels only stay lit for the emitted frame
                if (lit_chase)
                    for (int i = 0; i + q < n; i += 3)
                        px_store[i + q] = '0;
            end

            // pixel beat out: compare with the oldest one due
            if (m_tvalid && m_tready) begin
                seen.idx   = m_tdata[3:0];
                seen.red   = m_tdata[11:4];
                seen.green = m_tdata[19:12];
                seen.blue  = m_tdata[27:20];
                seen.last  = m_tlast;
                seen.done  = m_tuser;
                if (pixel_due.size() == 0) begin
                    report_mismatch("beat with nothing due, index", seen.idx, -1);
                end else begin
                    want = pixel_due.pop_front();
                    if (seen.idx != want.idx)
                        report_mismatch("pixel index", seen.idx, want.idx);
                    if (seen.red != want.red)
                        report_mismatch("red", seen.red, want.red);
                    if (seen.green != want.green)
                        report_mismatch("green", seen.green, want.green);
                    if (seen.blue != want.blue)
                        report_mismatch("blue", seen.blue, want.blue);
                    if (seen.last != want.last)
                        report_mismatch("tlast", seen.last, want.last);
                    if (seen.done != want.done)
                        report_mismatch("tuser", seen.done, want.done);
                    if (m_tdata[31:28] != 4'd0)
                        report_mismatch("tdata padding", m_tdata[31:28], 0);
                end
            end
        end
        beats_pending <= pixel_due.size();
        mismatches    <= tally;
    end

endmodule

// File: bench/tb_led_strip_effect_generator.sv
module tb_led_strip_effect_generator;
    import lseg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         LIMIT_CYCLES = 1_000_000;
    localparam int         SETTLE       = 64;
    localparam int         RANDOM_TICKS = 56;
    localparam logic [2:0] EFF_UNDEF_LO = 3'd5;
    localparam logic [2:0] EFF_UNDEF_HI = 3'd7;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_addr      = REG_EFFECT;
    logic [7:0]  cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [3:0] index, [11:4] red, [19:12] green, [27:20] blue
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    int          mismatches;
    int          beats_pending;
    int          cycle_count = 0;
    int          ticks_sent  = 0;
    logic        calm        = 1'b0;

    led_strip_effect_generator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    lseg_pixel_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_axis_tvalid),
        .s_tready      (s_axis_tready),
        .s_tdata       (s_axis_tdata),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .m_tdata       (m_axis_tdata),
        .m_tlast       (m_axis_tlast),
        .m_tuser       (m_axis_tuser),
        .mismatches    (mismatches),
        .beats_pending (beats_pending)
    );

    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // strip side back-pressure
    always @(posedge aclk)
        m_axis_tready <= calm || ($urandom_range(99) >= 19);

    task automatic cfg_write(input logic [2:0] addr, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // all five registers, back to back; block must be idle
    task automatic configure(input logic [2:0] eff, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [4:0] cnt);
        cfg_write(REG_EFFECT, {5'd0, eff});
        cfg_write(REG_RED, r);
        cfg_write(REG_GREEN, g);
        cfg_write(REG_BLUE, b);
        cfg_write(REG_COUNT, {3'd0, cnt});
        cfg_we <= 1'b0;
    endtask

    // one frame tick beat; tvalid stays high on return
    task automatic send_tick(input logic restart);
        while (!calm && $urandom_range(99) < 19) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do
            @(posedge aclk);
        while (!s_axis_tready);
        ticks_sent++;
    endtask

    // hold the sender until every pixel due has come out, then let the clear pass end
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (beats_pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        logic [2:0] eff;
        logic [4:0] cnt;
        int         start_ticks;
        int         run_len;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // idle after reset: store shown unchanged, effect done
        send_tick(1'b0);
        drain();

        // wipe to its end and one tick past it
        configure(EFF_WIPE, 8'hFF, 8'h00, 8'hFF, 5'd3);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        drain();

        // chase on a full strip, all channels at full scale
        configure(EFF_CHASE, 8'hFF, 8'hFF, 8'hFF, 5'd16);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        drain();

        // pixel count zero acts as one
        configure(EFF_RAINBOW, 8'h00, 8'h00, 8'h00, 5'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        drain();

        // counts above the strip saturate
        configure(EFF_CYCLE, 8'h5A, 8'hA5, 8'h00, 5'd31);
        send_tick(1'b1);
        send_tick(1'b0);
        drain();

        configure(EFF_CHASE_RB, 8'h00, 8'hFF, 8'h00, 5'd17);
        send_tick(1'b1);
        send_tick(1'b0);
        drain();

        // undefined selectors last one frame and draw nothing
        configure(EFF_UNDEF_HI, 8'hC3, 8'h3C, 8'h81, 5'd5);
        send_tick(1'b1);
        send_tick(1'b0);
        drain();

        configure(EFF_UNDEF_LO, 8'h01, 8'h02, 8'h03, 5'd16);
        send_tick(1'b1);
        drain();

        // shrink the strip mid-wipe: frame already past the new end
        configure(EFF_WIPE, 8'h12, 8'h34, 8'h56, 5'd16);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        drain();
        configure(EFF_WIPE, 8'h12, 8'h34, 8'h56, 5'd2);
        send_tick(1'b0);
        drain();

        // random effect runs, some continued without restart after a register change
        start_ticks = ticks_sent;
        while (ticks_sent - start_ticks < RANDOM_TICKS) begin
            eff = ($urandom_range(9) == 0) ? 3'($urandom_range(EFF_UNDEF_LO, EFF_UNDEF_HI))
                                           : 3'($urandom_range(EFF_WIPE, EFF_CHASE_RB));
            cnt = ($urandom_range(4) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(1, 8));
            configure(eff, 8'($urandom), 8'($urandom), 8'($urandom), cnt);
            if ($urandom_range(4) != 0)
                send_tick(1'b1);
            run_len = ($urandom_range(3) == 0) ? $urandom_range(20, 35) : $urandom_range(1, 10);
            repeat (run_len) send_tick($urandom_range(9) == 0);
            drain();
        end

        // no idling on either side for this stretch: full chase and one tick past its end
        calm <= 1'b1;
        configure(EFF_CHASE, 8'h80, 8'h40, 8'h20, 5'd16);
        send_tick(1'b1);
        repeat (30) send_tick(1'b0);
        drain();
        calm <= 1'b0;

        if (mismatches == 0 && beats_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
design/lseg_pkg.sv
design/lseg_ctrl.sv
design/lseg_dpath.sv
design/led_strip_effect_generator.sv
bench/lseg_pixel_checker.sv
bench/tb_led_strip_effect_generator.sv
